@@ hdl/bounded_request_queue_top_assert.svh @@
// ----------------------------------------------------------------------------
// Request queue assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_REQUEST_QUEUE_TOP_ASSERT_SVH
`define BOUNDED_REQUEST_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
`define BRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BRQ_ASSERT(lbl, prop, msg)
`define BRQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/brq_pkg.sv @@
// ----------------------------------------------------------------------------
// Request queue package
// Sizes, operation and status codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FD_W  = 16;
  localparam int TM_W  = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int RIX_W = 6;
  localparam int MAX_W = 7;
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP_OLD = 2'd1,
    OP_POP_NEW = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    push;      // write at tail, count up, report ok
    logic    err;       // report err_code, nothing changes
    status_t err_code;
    logic    rd_first;  // read the entry being removed
    logic    capt;      // latch removed entry, read its successor
    logic    shift;     // move one entry down a slot
    logic    finish;    // count down, report ok
  } brq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_bad;
    logic more_capt;
    logic more_shift;
  } brq_sts_t;

endpackage

@@ hdl/brq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Request queue controller
// Decodes an operation and steps the removal/compaction sequence.
// ----------------------------------------------------------------------------
module brq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  brq_pkg::op_t      op,
  input  brq_pkg::brq_sts_t sts,
  output brq_pkg::brq_cmd_t cmd,
  output logic              busy
);
  import brq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CAPT, S_SHIFT} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.err_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_PUSH: begin
              if (sts.full) begin
                cmd.err      = 1'b1;
                cmd.err_code = ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            OP_POP_OLD, OP_POP_NEW: begin
              if (sts.empty) begin
                cmd.err      = 1'b1;
                cmd.err_code = ST_RANGE;
              end else begin
                cmd.rd_first = 1'b1;
                state_nxt    = S_CAPT;
              end
            end
            default: begin
              if (sts.idx_bad) begin
                cmd.err      = 1'b1;
                cmd.err_code = ST_RANGE;
              end else begin
                cmd.rd_first = 1'b1;
                state_nxt    = S_CAPT;
              end
            end
          endcase
        end
      end
      S_CAPT: begin
        cmd.capt = 1'b1;
        if (sts.more_capt) begin
          state_nxt = S_SHIFT;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.more_shift) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

@@ hdl/brq_datapath.sv @@
// ----------------------------------------------------------------------------
// Request queue datapath
// Entry memory, count, capacity register, compaction pointer, result regs.
// ----------------------------------------------------------------------------
module brq_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brq_pkg::brq_cmd_t           cmd,
  output brq_pkg::brq_sts_t           sts,
  input  brq_pkg::op_t                op,
  input  logic [brq_pkg::FD_W-1:0]    entry_fd,
  input  logic [brq_pkg::TM_W-1:0]    entry_time,
  input  logic [brq_pkg::RIX_W-1:0]   remove_index,
  input  logic                        cfg_wr_en,
  input  logic [brq_pkg::MAX_W-1:0]   cfg_wr_data,
  output logic                        res_valid,
  output logic [brq_pkg::ST_W-1:0]    res_status,
  output logic [brq_pkg::FD_W-1:0]    res_fd,
  output logic [brq_pkg::TM_W-1:0]    res_time,
  output logic [brq_pkg::CNT_W-1:0]   res_count
);
  import brq_pkg::*;

  logic [FD_W-1:0]  mem_fd   [DEPTH];
  logic [TM_W-1:0]  mem_time [DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [MAX_W-1:0] max_r;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [FD_W-1:0]  rd_fd_r;
  logic [TM_W-1:0]  rd_time_r;
  logic             valid_r;
  logic [ST_W-1:0]  status_r;
  logic [FD_W-1:0]  fd_r;
  logic [TM_W-1:0]  time_r;

  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic [FD_W-1:0]  wr_fd;
  logic [TM_W-1:0]  wr_time;
  logic [CNT_W:0]   ptr_p1;
  logic [CNT_W:0]   ptr_p2;

  // removal position of the incoming operation
  always_comb begin
    case (op)
      OP_POP_OLD: pos = '0;
      OP_POP_NEW: pos = IDX_W'(count_r - CNT_W'(1));
      default:    pos = IDX_W'(remove_index);
    endcase
  end

  assign ptr_p1 = (CNT_W+1)'(ptr_r) + (CNT_W+1)'(1);
  assign ptr_p2 = (CNT_W+1)'(ptr_r) + (CNT_W+1)'(2);

  assign sts.full       = (count_r >= CNT_W'(max_r)) || (count_r >= CNT_W'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.idx_bad    = (CNT_W'(remove_index) >= count_r);
  assign sts.more_capt  = (ptr_p1 < (CNT_W+1)'(count_r));
  assign sts.more_shift = (ptr_p2 < (CNT_W+1)'(count_r));

  always_comb begin
    if (cmd.rd_first) begin
      rd_addr = pos;
    end else if (cmd.capt) begin
      rd_addr = ptr_p1[IDX_W-1:0];
    end else begin
      rd_addr = ptr_p2[IDX_W-1:0];
    end
  end

  assign wr_en   = cmd.push | cmd.shift;
  assign wr_addr = cmd.push ? count_r[IDX_W-1:0] : ptr_r;
  assign wr_fd   = cmd.push ? entry_fd   : rd_fd_r;
  assign wr_time = cmd.push ? entry_time : rd_time_r;

  // entry storage: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_fd[wr_addr]   <= wr_fd;
      mem_time[wr_addr] <= wr_time;
    end
    rd_fd_r   <= mem_fd[rd_addr];
    rd_time_r <= mem_time[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.finish) begin
      count_nxt = count_r - CNT_W'(1);
    end
    ptr_nxt = ptr_r;
    if (cmd.rd_first) begin
      ptr_nxt = pos;
    end else if (cmd.shift) begin
      ptr_nxt = ptr_p1[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= MAX_RESET;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= cmd.push | cmd.err | cmd.finish;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.push || cmd.err) begin
      fd_r     <= '0;
      time_r   <= '0;
    end else if (cmd.capt) begin
      fd_r     <= rd_fd_r;
      time_r   <= rd_time_r;
    end
    if (cmd.err) begin
      status_r <= cmd.err_code;
    end else if (cmd.push || cmd.finish) begin
      status_r <= ST_OK;
    end
  end

  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_fd     = fd_r;
  assign res_time   = time_r;
  assign res_count  = count_r;

`include "bounded_request_queue_top_assert.svh"

  `BRQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "count above depth")
  `BRQ_ASSERT(a_push_room, cmd.push |-> !sts.full, "push while full")
  `BRQ_ASSERT(a_shift_src, cmd.shift |-> (ptr_p1 < (CNT_W+1)'(count_r)), "shift past tail")
  `BRQ_ASSERT_NEXT(a_finish_dec, cmd.finish, count_r == $past(count_r) - CNT_W'(1), "count stuck")

endmodule

@@ hdl/bounded_request_queue_top.sv @@
// ----------------------------------------------------------------------------
// Bounded request queue, top level
// Ordered queue of (fd, time) entries with push, pop oldest, pop newest and
// indexed removal that keeps the remaining entries in order.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  -----------------------------------
//  in_       start & !busy -> transfer  operation, entry_fd, entry_time,
//                                       remove_index
//  out_      out_valid (1 cycle)        status, fd, time, count
//  cfg_      cfg_wr_en                  cfg_wr_data = max_entries
//
//  Push and any flagged operation: result in the cycle after the transfer, busy
//  stays low, so one such operation per cycle.
//  Removal at position p: busy while the entry is read and then each later
//  entry is moved down a slot, result the cycle after busy ends.
//  The entry memory has one read and one write port and moves one entry per
//  cycle; that sets the rate.
//  Reset (rst_n low, synchronous): count 0, capacity 64; entries left as is.
//  Results cannot be stalled: out_valid pulses for one cycle per transfer.
//
module bounded_request_queue_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic [brq_pkg::OP_W-1:0]    in_operation,
  input  logic [brq_pkg::FD_W-1:0]    in_entry_fd,
  input  logic [brq_pkg::TM_W-1:0]    in_entry_time,
  input  logic [brq_pkg::RIX_W-1:0]   in_remove_index,
  // result channel
  output logic                        out_valid,
  output logic [brq_pkg::ST_W-1:0]    out_status,
  output logic [brq_pkg::FD_W-1:0]    out_fd,
  output logic [brq_pkg::TM_W-1:0]    out_time,
  output logic [brq_pkg::CNT_W-1:0]   out_count,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [brq_pkg::MAX_W-1:0]   cfg_wr_data
);
  import brq_pkg::*;

  brq_cmd_t cmd;
  brq_sts_t sts;
  op_t      op;

  assign op = op_t'(in_operation);

  // sequencer: decode, then read / move entries
  brq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage, count, capacity and result registers
  brq_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .entry_fd     (in_entry_fd),
    .entry_time   (in_entry_time),
    .remove_index (in_remove_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .res_valid    (out_valid),
    .res_status   (out_status),
    .res_fd       (out_fd),
    .res_time     (out_time),
    .res_count    (out_count)
  );

endmodule
